FILE: sv/mrtd_pkg.sv
package mrtd_pkg;

   // Work mode codes; any code other than battery low or sleep is "other"
   localparam logic [1:0] MODE_OTHER  = 2'd0;
   localparam logic [1:0] MODE_BATLOW = 2'd1;
   localparam logic [1:0] MODE_SLEEP  = 2'd2;

   // Saturation value of the display-hold timer
   localparam logic [7:0] HOLD_MAX = 8'd250;

   // Register reset values
   localparam logic [7:0] BLINK_TICKS_RST  = 8'd50;
   localparam logic [7:0] PERIOD_150_RST   = 8'd75;
   localparam logic [7:0] PERIOD_50_RST    = 8'd25;
   localparam logic [7:0] PERIOD_700_RST   = 8'd14;
   localparam logic [7:0] PERIOD_2S_RST    = 8'd40;
   localparam logic [7:0] LOWBAT_LIMIT_RST = 8'd60;

   // Register indexes on the CSR port
   typedef enum logic [2:0] {
      CSR_BLINK_TICKS  = 3'd0,
      CSR_PERIOD_150   = 3'd1,
      CSR_PERIOD_50    = 3'd2,
      CSR_PERIOD_700   = 3'd3,
      CSR_PERIOD_2S    = 3'd4,
      CSR_LOWBAT_LIMIT = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic       blink_request;
      logic [1:0] work_mode;
      logic       restart_hold;
      logic       ack_shutdown;
   } req_payload_type;

   typedef struct packed {
      logic       blink_done;
      logic       led_on_req;
      logic       blink_active;
      logic       pulse_150;
      logic       pulse_50;
      logic       pulse_700;
      logic       pulse_2s;
      logic       shutdown_req;
      logic [7:0] hold_time;
   } rsp_payload_type;

   typedef struct packed {
      logic [2:0] index;
      logic [7:0] data;
   } csr_payload_type;

endpackage

FILE: sv/mrtd_chan_if.sv
interface mrtd_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/multi_rate_tick_divider.sv
// A result is registered and valid on rsp_chan in the cycle after its request is accepted.
// Throughput: one request per cycle; the single result register frees up in
// the same cycle it is taken, so req_chan.ready = !rsp valid || rsp_chan.ready.
// CSR writes are always ready and take effect in the cycle after they are accepted.
// Reset (synchronous, active high) clears all counters and flags, empties the
// result register and loads the register defaults.
module multi_rate_tick_divider (
   input logic       clock,
   input logic       reset,
   mrtd_chan_if.sink   req_chan,
   mrtd_chan_if.source rsp_chan,
   mrtd_chan_if.sink   csr_chan
);
   import mrtd_pkg::*;

   typedef struct packed {
      logic [7:0] count;
      logic       fire;
   } div_step_type;

   // One divider step: increment, and clear with a pulse when the limit is reached
   function automatic div_step_type div_step(input logic [7:0] count,
                                             input logic [7:0] limit);
      div_step_type res;
      logic [8:0]   nxt;
      nxt = {1'b0, count} + 9'd1;
      if (nxt >= {1'b0, limit}) begin
         res.count = 8'd0;
         res.fire  = 1'b1;
      end else begin
         res.count = nxt[7:0];
         res.fire  = 1'b0;
      end
      return res;
   endfunction

   // Configuration registers
   logic [7:0] blink_ticks_ff, period_150_ff, period_50_ff;
   logic [7:0] period_700_ff, period_2s_ff, lowbat_limit_ff;

   // Timing state
   logic       blink_flag_ff, blink_flag_in;
   logic [7:0] blink_count_ff, blink_count_in;
   logic [7:0] count_150_ff, count_150_in;
   logic [7:0] count_50_ff, count_50_in;
   logic [7:0] count_700_ff, count_700_in;
   logic [7:0] count_2s_ff, count_2s_in;
   logic [7:0] lowbat_count_ff, lowbat_count_in;
   logic       shutdown_flag_ff, shutdown_flag_in;
   logic [7:0] hold_timer_ff, hold_timer_in;

   // Result register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic            req_accept;
   logic            csr_accept;
   req_payload_type req;
   csr_payload_type csr;

   assign req = req_chan.payload;
   assign csr = csr_chan.payload;

   // Handshakes
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign csr_accept     = csr_chan.valid;

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

   // Next-state and result for one tick
   always_comb begin
      div_step_type blink_step, s150, s50, s700, s2s;
      logic         flag_pre;
      logic         sd_pre;
      logic [7:0]   hold_pre;
      logic [8:0]   lowbat_nxt;

      hold_pre = req.restart_hold ? 8'd0 : hold_timer_ff;
      sd_pre   = req.ack_shutdown ? 1'b0 : shutdown_flag_ff;
      flag_pre = req.blink_request | blink_flag_ff;

      rsp_payload_in = '0;

      // Blink window
      blink_step     = div_step(blink_count_ff, blink_ticks_ff);
      blink_flag_in  = flag_pre;
      blink_count_in = 8'd0;
      if (flag_pre) begin
         blink_count_in = blink_step.count;
         if (blink_step.fire) begin
            blink_flag_in             = 1'b0;
            rsp_payload_in.blink_done = 1'b1;
            rsp_payload_in.led_on_req = (req.work_mode != MODE_SLEEP);
         end
      end

      // Base-tick dividers
      s150         = div_step(count_150_ff, period_150_ff);
      s50          = div_step(count_50_ff, period_50_ff);
      count_150_in = s150.count;
      count_50_in  = s50.count;

      // Slow dividers, low-battery counter and hold timer on the 50 ms pulse
      s700             = div_step(count_700_ff, period_700_ff);
      s2s              = div_step(count_2s_ff, period_2s_ff);
      lowbat_nxt       = {1'b0, lowbat_count_ff} + 9'd1;
      count_700_in     = count_700_ff;
      count_2s_in      = count_2s_ff;
      lowbat_count_in  = lowbat_count_ff;
      shutdown_flag_in = sd_pre;
      hold_timer_in    = hold_pre;
      if (s50.fire) begin
         count_700_in             = s700.count;
         count_2s_in              = s2s.count;
         rsp_payload_in.pulse_700 = s700.fire;
         rsp_payload_in.pulse_2s  = s2s.fire;
         if (s2s.fire) begin
            if (req.work_mode == MODE_BATLOW) begin
               if (lowbat_nxt >= {1'b0, lowbat_limit_ff}) begin
                  lowbat_count_in  = lowbat_limit_ff;
                  shutdown_flag_in = 1'b1;
               end else begin
                  lowbat_count_in = lowbat_nxt[7:0];
               end
            end else begin
               lowbat_count_in = 8'd0;
            end
         end
         if (hold_pre < HOLD_MAX) begin
            hold_timer_in = hold_pre + 8'd1;
         end
      end

      rsp_payload_in.blink_active = blink_flag_in;
      rsp_payload_in.pulse_150    = s150.fire;
      rsp_payload_in.pulse_50     = s50.fire;
      rsp_payload_in.shutdown_req = shutdown_flag_in;
      rsp_payload_in.hold_time    = hold_timer_in;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         blink_ticks_ff  <= BLINK_TICKS_RST;
         period_150_ff   <= PERIOD_150_RST;
         period_50_ff    <= PERIOD_50_RST;
         period_700_ff   <= PERIOD_700_RST;
         period_2s_ff    <= PERIOD_2S_RST;
         lowbat_limit_ff <= LOWBAT_LIMIT_RST;
      end else if (csr_accept) begin
         case (csr_index_type'(csr.index))
            CSR_BLINK_TICKS:  blink_ticks_ff  <= csr.data;
            CSR_PERIOD_150:   period_150_ff   <= csr.data;
            CSR_PERIOD_50:    period_50_ff    <= csr.data;
            CSR_PERIOD_700:   period_700_ff   <= csr.data;
            CSR_PERIOD_2S:    period_2s_ff    <= csr.data;
            CSR_LOWBAT_LIMIT: lowbat_limit_ff <= csr.data;
            default: ;
         endcase
      end
   end

   // Timing state, advanced once per accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         blink_flag_ff    <= 1'b0;
         blink_count_ff   <= 8'd0;
         count_150_ff     <= 8'd0;
         count_50_ff      <= 8'd0;
         count_700_ff     <= 8'd0;
         count_2s_ff      <= 8'd0;
         lowbat_count_ff  <= 8'd0;
         shutdown_flag_ff <= 1'b0;
         hold_timer_ff    <= 8'd0;
      end else if (req_accept) begin
         blink_flag_ff    <= blink_flag_in;
         blink_count_ff   <= blink_count_in;
         count_150_ff     <= count_150_in;
         count_50_ff      <= count_50_in;
         count_700_ff     <= count_700_in;
         count_2s_ff      <= count_2s_in;
         lowbat_count_ff  <= lowbat_count_in;
         shutdown_flag_ff <= shutdown_flag_in;
         hold_timer_ff    <= hold_timer_in;
      end
   end

   // Result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   // An accepted request always leaves a result behind
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("result missing after accepted request");

   // Slow pulses only ride on a 50 ms pulse
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_payload_ff.pulse_700 || rsp_payload_ff.pulse_2s)
      |-> rsp_payload_ff.pulse_50)
      else $error("slow pulse without 50 ms pulse");

   // Blink counter only runs while the window is armed
   assert property (@(posedge clock) disable iff (reset)
      (blink_count_ff != 8'd0) |-> blink_flag_ff)
      else $error("blink counter running with window closed");

   // Hold timer saturates
   assert property (@(posedge clock) disable iff (reset)
      hold_timer_ff <= HOLD_MAX)
      else $error("hold timer past saturation");

endmodule
